// ----- src/avsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package avsc_pkg;

    // Width of every timestamp, clock value and threshold.
    localparam int TIME_WIDTH = 32;
    localparam int REQ_WIDTH  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // s_tdata: event_param, current_clock, current_video_pts
    localparam int S_DATA_W = 3 * TIME_WIDTH;
    // m_tdata: ten result fields, rounded up to whole bytes
    localparam int M_FIELDS_W = 4 + 3 * TIME_WIDTH + 2 + 2;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [TIME_WIDTH-1:0] TIME_HALF = {1'b1, {(TIME_WIDTH-1){1'b0}}};

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_VSTART   = 4'd0,
        REQ_VSTOP    = 4'd1,
        REQ_VPAUSE   = 4'd2,
        REQ_VDISC    = 4'd3,
        REQ_ASTART   = 4'd4,
        REQ_ARESUME  = 4'd5,
        REQ_ASTOP    = 4'd6,
        REQ_APAUSE   = 4'd7,
        REQ_ADISC    = 4'd8,
        REQ_APTS     = 4'd9,
        REQ_ABREAK   = 4'd10,
        REQ_DECRESET = 4'd11
    } req_t;

    typedef enum logic [1:0] {
        SETUP_NONE  = 2'd0,
        SETUP_VIDEO = 2'd1,
        SETUP_AUDIO = 2'd2
    } setup_t;

    typedef enum logic {
        MODE_VIDEO = 1'b0,
        MODE_AUDIO = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_ENABLE   = 3'd0,
        CFG_STOP_TO_VIDEO = 3'd1,
        CFG_HOLD_ENABLE   = 3'd2,
        CFG_AV_THRESHOLD  = 3'd3,
        CFG_DISC_THRESH   = 3'd4,
        CFG_HOLD_OFFSET   = 3'd5,
        CFG_MATCH_WINDOW  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic                  sync_enable;
        logic                  stop_to_video;
        logic                  hold_enable;
        logic [TIME_WIDTH-1:0] av_threshold;
        logic [TIME_WIDTH-1:0] discontinuity_threshold;
        logic [TIME_WIDTH-1:0] video_hold_offset;
        logic [TIME_WIDTH-1:0] audio_match_window;
    } cfg_t;

    typedef struct packed {
        mode_t  mode;
        setup_t setup;
        logic   abrk_flag;
        logic   dec_reset_pending;
    } state_t;

    // Event as held in the input register, with the event_param - clock
    // distance already reduced to a magnitude.
    typedef struct packed {
        logic [REQ_WIDTH-1:0]  req;
        logic [TIME_WIDTH-1:0] param;
        logic [TIME_WIDTH-1:0] video_pts;
        logic [TIME_WIDTH-1:0] dist_mag;
        logic                  dist_half;  // difference is the most negative value
    } event_t;

    typedef struct packed {
        logic                  clock_write;
        logic [TIME_WIDTH-1:0] clock_value;
        logic                  video_pts_write;
        logic [TIME_WIDTH-1:0] video_pts_value;
        logic                  audio_pts_write;
        logic [TIME_WIDTH-1:0] audio_pts_value;
        logic                  run_change;
        logic                  clock_run;
        mode_t                 master_mode;
        setup_t                setup_state;
    } result_t;

endpackage

`default_nettype wire

// ----- src/av_sync_clock_master_control_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                      Payload
// s_        in   s_tvalid/tready/tdata/tuser  one sync event (req_type in tuser)
// m_        out  m_tvalid/tready/tdata      one result beat per event
// cfg_      in   cfg_wr_en/index/wdata      register writes, no handshake
//
// Every event yields exactly one result beat. An event is held in the input
// register, then the decision logic and state update run and the result
// register loads; a beat can be taken every clock while m_tready is high.
// While a finished beat waits on m_tready the input register takes at most one
// more event, then both registers hold. Synchronous active-low reset restores
// the register defaults, audio master and no setup.
module av_sync_clock_master_control_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // [31:0] event_param, [63:32] current_clock, [95:64] current_video_pts
    input  wire logic [avsc_pkg::S_DATA_W-1:0]    s_tdata,
    // [3:0] req_type
    input  wire logic [avsc_pkg::REQ_WIDTH-1:0]   s_tuser,

    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // [0] clock_write, [32:1] clock_value, [33] video_pts_write,
    // [65:34] video_pts_value, [66] audio_pts_write, [98:67] audio_pts_value,
    // [99] run_change, [100] clock_run, [101] master_mode, [103:102] setup_state
    output      logic [avsc_pkg::M_DATA_W-1:0]    m_tdata,

    input  wire logic                             cfg_wr_en,
    input  wire logic [avsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [avsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int TW = avsc_pkg::TIME_WIDTH;

    avsc_pkg::cfg_t    cfg;
    avsc_pkg::event_t  evt_reg, evt_next;
    avsc_pkg::state_t  st_reg, st_next;
    avsc_pkg::result_t res_reg, res_next;
    logic              in_vld_reg, in_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic              s_beat;
    logic              advance;
    logic [TW-1:0]     s_param, s_clock, s_vpts, pc_diff;

    avsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    avsc_decide u_decide (
        .evt     (evt_reg),
        .cfg     (cfg),
        .st      (st_reg),
        .res     (res_next),
        .st_next (st_next)
    );

    // Handshake: the decision stage moves when its result slot is free or is being read out.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    // Input side: reduce event_param - clock to a magnitude while capturing.
    assign s_param = s_tdata[TW-1:0];
    assign s_clock = s_tdata[2*TW-1:TW];
    assign s_vpts  = s_tdata[3*TW-1:2*TW];
    assign pc_diff = s_param - s_clock;

    always_comb begin
        evt_next           = evt_reg;
        if (s_beat) begin
            evt_next.req       = s_tuser;
            evt_next.param     = s_param;
            evt_next.video_pts = s_vpts;
            evt_next.dist_mag  = pc_diff[TW-1] ? (TW'(0) - pc_diff) : pc_diff;
            evt_next.dist_half = (pc_diff == avsc_pkg::TIME_HALF);
        end
    end

    assign in_vld_next  = s_beat || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg.mode              <= avsc_pkg::MODE_AUDIO;
            st_reg.setup             <= avsc_pkg::SETUP_NONE;
            st_reg.abrk_flag         <= 1'b0;
            st_reg.dec_reset_pending <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        evt_reg <= evt_next;
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = avsc_pkg::M_DATA_W'({
        res_reg.setup_state,
        res_reg.master_mode,
        res_reg.clock_run,
        res_reg.run_change,
        res_reg.audio_pts_value,
        res_reg.audio_pts_write,
        res_reg.video_pts_value,
        res_reg.video_pts_write,
        res_reg.clock_value,
        res_reg.clock_write
    });

endmodule

`default_nettype wire

// ----- src/avsc_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module avsc_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [avsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [avsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output avsc_pkg::cfg_t                        cfg
);

    avsc_pkg::cfg_t cfg_reg;
    avsc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (avsc_pkg::cfg_idx_t'(cfg_index))
                avsc_pkg::CFG_SYNC_ENABLE:   cfg_next.sync_enable   = cfg_wdata[0];
                avsc_pkg::CFG_STOP_TO_VIDEO: cfg_next.stop_to_video = cfg_wdata[0];
                avsc_pkg::CFG_HOLD_ENABLE:   cfg_next.hold_enable   = cfg_wdata[0];
                avsc_pkg::CFG_AV_THRESHOLD:
                    cfg_next.av_threshold = cfg_wdata[avsc_pkg::TIME_WIDTH-1:0];
                avsc_pkg::CFG_DISC_THRESH:
                    cfg_next.discontinuity_threshold = cfg_wdata[avsc_pkg::TIME_WIDTH-1:0];
                avsc_pkg::CFG_HOLD_OFFSET:
                    cfg_next.video_hold_offset = cfg_wdata[avsc_pkg::TIME_WIDTH-1:0];
                avsc_pkg::CFG_MATCH_WINDOW:
                    cfg_next.audio_match_window = cfg_wdata[avsc_pkg::TIME_WIDTH-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_enable             <= 1'b1;
            cfg_reg.stop_to_video           <= 1'b0;
            cfg_reg.hold_enable             <= 1'b1;
            cfg_reg.av_threshold            <= avsc_pkg::TIME_WIDTH'(5400000);
            cfg_reg.discontinuity_threshold <= avsc_pkg::TIME_WIDTH'(5400000);
            cfg_reg.video_hold_offset       <= avsc_pkg::TIME_WIDTH'(9000);
            cfg_reg.audio_match_window      <= avsc_pkg::TIME_WIDTH'(9000);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/avsc_decide.sv -----
`timescale 1ns / 1ps
`default_nettype none

module avsc_decide (
    input  wire avsc_pkg::event_t  evt,
    input  wire avsc_pkg::cfg_t    cfg,
    input  wire avsc_pkg::state_t  st,
    output avsc_pkg::result_t      res,
    output avsc_pkg::state_t       st_next
);

    logic                            off_av;     // beyond av_threshold
    logic                            off_disc;   // beyond discontinuity threshold
    logic                            off_match;  // beyond audio match window
    logic [avsc_pkg::TIME_WIDTH-1:0] p;
    logic [avsc_pkg::TIME_WIDTH-1:0] held_p;
    logic [avsc_pkg::TIME_WIDTH-1:0] min_p;

    assign p         = evt.param;
    assign off_av    = evt.dist_half | (evt.dist_mag > cfg.av_threshold);
    assign off_disc  = evt.dist_half | (evt.dist_mag > cfg.discontinuity_threshold);
    assign off_match = evt.dist_half | (evt.dist_mag > cfg.audio_match_window);
    assign held_p    = p - cfg.video_hold_offset;
    assign min_p     = (p < evt.video_pts) ? p : evt.video_pts;

    always_comb begin
        res     = '0;
        st_next = st;
        unique case (evt.req)
            avsc_pkg::REQ_VSTART: begin
                st_next.mode = cfg.sync_enable ? avsc_pkg::MODE_AUDIO : avsc_pkg::MODE_VIDEO;
                if (st.setup == avsc_pkg::SETUP_NONE) begin
                    res.clock_write = 1'b1;
                    res.clock_value = (cfg.hold_enable && cfg.sync_enable) ? held_p : p;
                    st_next.setup   = avsc_pkg::SETUP_VIDEO;
                end else if (st.setup == avsc_pkg::SETUP_AUDIO && off_av) begin
                    res.clock_write = 1'b1;
                    res.clock_value = p;
                    st_next.setup   = avsc_pkg::SETUP_VIDEO;
                end
                res.run_change = 1'b1;
                res.clock_run  = 1'b1;
            end
            avsc_pkg::REQ_VSTOP: begin
                st_next.setup       = avsc_pkg::SETUP_NONE;
                res.video_pts_write = 1'b1;
                res.run_change      = 1'b1;
            end
            avsc_pkg::REQ_VPAUSE: begin
                res.run_change = 1'b1;
                res.clock_run  = (p != avsc_pkg::TIME_WIDTH'(1));
            end
            avsc_pkg::REQ_VDISC: begin
                if (off_disc) begin
                    st_next.mode        = avsc_pkg::MODE_VIDEO;
                    st_next.setup       = avsc_pkg::SETUP_VIDEO;
                    res.video_pts_write = 1'b1;
                    res.video_pts_value = p;
                    res.clock_write     = 1'b1;
                    res.clock_value     = p;
                end else if (cfg.sync_enable) begin
                    st_next.mode = avsc_pkg::MODE_AUDIO;
                end
            end
            avsc_pkg::REQ_ASTART: begin
                // after an audio break, wait until audio is back near the clock
                if (cfg.sync_enable && !(st.abrk_flag && off_match)) begin
                    st_next.abrk_flag         = 1'b0;
                    st_next.dec_reset_pending = 1'b0;
                    res.clock_write     = 1'b1;
                    res.clock_value     = st.dec_reset_pending ? min_p : p;
                    res.audio_pts_write = 1'b1;
                    res.audio_pts_value = p;
                    st_next.setup       = avsc_pkg::SETUP_AUDIO;
                    res.run_change      = 1'b1;
                    res.clock_run       = 1'b1;
                end
            end
            avsc_pkg::REQ_ARESUME: begin
                res.run_change = cfg.sync_enable;
                res.clock_run  = cfg.sync_enable;
            end
            avsc_pkg::REQ_ASTOP: begin
                st_next.abrk_flag = 1'b0;
                st_next.setup = cfg.stop_to_video ? avsc_pkg::SETUP_VIDEO : avsc_pkg::SETUP_NONE;
            end
            avsc_pkg::REQ_APAUSE: begin
                res.run_change = cfg.sync_enable;
            end
            avsc_pkg::REQ_ADISC: begin
                if (cfg.sync_enable) begin
                    if (off_disc) begin
                        st_next.mode        = avsc_pkg::MODE_VIDEO;
                        res.audio_pts_write = 1'b1;
                        res.audio_pts_value = p;
                    end else begin
                        st_next.mode = avsc_pkg::MODE_AUDIO;
                    end
                end
            end
            avsc_pkg::REQ_APTS: begin
                res.audio_pts_write = 1'b1;
                res.audio_pts_value = p;
                st_next.abrk_flag   = 1'b0;
                if (cfg.sync_enable) begin
                    if (off_av) begin
                        st_next.mode = avsc_pkg::MODE_VIDEO;
                    end else begin
                        st_next.mode    = avsc_pkg::MODE_AUDIO;
                        res.clock_write = 1'b1;
                        res.clock_value = p;
                    end
                end
            end
            avsc_pkg::REQ_ABREAK: begin
                st_next.abrk_flag = (p != '0);
            end
            avsc_pkg::REQ_DECRESET: begin
                st_next.dec_reset_pending = 1'b1;
            end
            default: ;  // undefined request: no action
        endcase
        res.master_mode = st_next.mode;
        res.setup_state = st_next.setup;
    end

endmodule

`default_nettype wire
